/* src/mts_pkg.sv */
// Package for the minimum tracking stack: sizes, data types and codes.
// Used by the response channel interface and the top level.
package mts_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int AW         = $clog2(DEPTH);
	localparam int PTR_W      = $clog2(DEPTH + 1);
	localparam int FILL_W     = 7;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [PTR_W-1:0]             ptr_t;
	typedef logic [AW-1:0]                addr_t;

	typedef struct packed {
		data_t val;
		ptr_t  cnt;
	} min_ent_t;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_PEEK = 2'd2;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_POP_EMPTY = 2'd1,
		ERR_PUSH_FULL = 2'd2
	} err_t;

	function automatic data_t to_data(input logic signed [31:0] v);
		return data_t'(v);
	endfunction

	function automatic logic signed [31:0] to_out(input data_t v);
		return 32'(v);
	endfunction

endpackage

/* src/mts_if.sv */
// Request and response channel interfaces of the minimum tracking stack.
// Depends on mts_pkg for the error code type and the fill level width.
interface mts_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] push_value;

	modport source (output valid, output action, output push_value, input ready);
	modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface mts_rsp_if import mts_pkg::*; ;
	logic               valid;
	logic               ready;
	logic signed [31:0] top_value;
	logic signed [31:0] min_value;
	logic [FILL_W-1:0]  fill_level;
	logic               is_empty;
	err_t               error_code;

	modport source (output valid, output top_value, output min_value, output fill_level,
		output is_empty, output error_code, input ready);
	modport sink   (input valid, input top_value, input min_value, input fill_level,
		input is_empty, input error_code, output ready);
endinterface

/* src/min_tracking_stack_unit.sv */
// Top level of the minimum tracking stack: value stack plus a stack of
// (minimum, count) pairs. Depends on mts_pkg, mts_if and mts_ram.
//
//  channel | dir | payload                                               | handshake
//  req     | in  | action, push_value                                    | valid/ready
//  rsp     | out | top_value, min_value, fill_level, is_empty, error_code | valid/ready
//
// One request is taken every cycle unless a stalled response holds it; its
// response is registered and appears in the next cycle. The top entries of both
// stacks live in registers, the rest in two RAMs whose entry below the top is read
// ahead every cycle, with a bypass after a write. No clearing pass follows reset.
module min_tracking_stack_unit import mts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	mts_req_if.sink  req,
	mts_rsp_if.source rsp
);

	ptr_t     vptr_q, vptr_d, mptr_q, mptr_d;
	data_t    top_q, top_d, v_in;
	min_ent_t mtop_q, mtop_d, m_below, m_rdata, mbyp_data_q;
	data_t    v_below, v_rdata, vbyp_data_q;
	logic     vbyp_q, mbyp_q, vwe, mwe, accept, empty;
	err_t     err;
	logic     rsp_valid_q;

	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign v_in      = to_data(req.push_value);
	assign v_below   = vbyp_q ? vbyp_data_q : v_rdata;
	assign m_below   = mbyp_q ? mbyp_data_q : m_rdata;

	always_comb begin
		vptr_d = vptr_q;
		mptr_d = mptr_q;
		top_d  = top_q;
		mtop_d = mtop_q;
		vwe    = 1'b0;
		mwe    = 1'b0;
		err    = ERR_OK;
		if (accept) begin
			case (req.action)
				ACT_PUSH: begin
					if (vptr_q == PTR_W'(DEPTH)) begin
						err = ERR_PUSH_FULL;
					end else begin
						vwe    = vptr_q != '0;
						top_d  = v_in;
						vptr_d = vptr_q + 1'b1;
						if (mptr_q == '0 || mtop_q.val > v_in) begin
							mwe        = mptr_q != '0;
							mtop_d.val = v_in;
							mtop_d.cnt = PTR_W'(1);
							mptr_d     = mptr_q + 1'b1;
						end else if (mtop_q.val == v_in) begin
							mtop_d.cnt = mtop_q.cnt + 1'b1;
						end
					end
				end
				ACT_POP: begin
					if (vptr_q == '0) begin
						err = ERR_POP_EMPTY;
					end else begin
						top_d  = v_below;
						vptr_d = vptr_q - 1'b1;
						if (mptr_q != '0 && mtop_q.val == top_q) begin
							if (mtop_q.cnt <= PTR_W'(1)) begin
								mptr_d = mptr_q - 1'b1;
								mtop_d = m_below;
							end else begin
								mtop_d.cnt = mtop_q.cnt - 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign empty = vptr_d == '0;

	mts_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (vwe),
		.waddr (AW'(vptr_q - PTR_W'(1))),
		.wdata (top_q),
		.raddr (AW'(vptr_d - PTR_W'(2))),
		.rdata (v_rdata)
	);

	mts_ram #(.WIDTH($bits(min_ent_t)), .DEPTH(DEPTH)) u_min_ram (
		.clk   (clk),
		.we    (mwe),
		.waddr (AW'(mptr_q - PTR_W'(1))),
		.wdata (mtop_q),
		.raddr (AW'(mptr_d - PTR_W'(2))),
		.rdata (m_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vptr_q      <= '0;
			mptr_q      <= '0;
			vbyp_q      <= 1'b0;
			mbyp_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			vptr_q <= vptr_d;
			mptr_q <= mptr_d;
			vbyp_q <= vwe;
			mbyp_q <= mwe;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q       <= top_d;
		mtop_q      <= mtop_d;
		vbyp_data_q <= top_q;
		mbyp_data_q <= mtop_q;
		if (accept) begin
			rsp.top_value  <= empty ? '0 : to_out(top_d);
			rsp.min_value  <= (empty || mptr_d == '0) ? '0 : to_out(mtop_d.val);
			rsp.fill_level <= FILL_W'(vptr_d);
			rsp.is_empty   <= empty;
			rsp.error_code <= err;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

/* src/mts_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// A read at the address being written returns the old contents.
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
